FILE: rtl/adl_pkg.sv
// Shared widths and command and status codes of the linked list block.
`timescale 1ns / 1ps
`default_nettype none
package adl_pkg;

  localparam int unsigned IdW   = 11;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 2;

  typedef logic [CmdW-1:0]  cmd_t;
  typedef logic [StatW-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_ABSENT  = 2'd1;
  localparam status_t ST_REFUSED = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/array_doubly_linked_list.sv
// Top level of the array-backed doubly linked list with its command sequencer.
//
// The block keeps an ordered list of entries numbered 1 to MAX_IDS in two link
// memories and answers one result beat for every command beat. After reset the
// list holds only entry 1 and no clearing pass is needed: entries at or above the
// next free id are known to be absent, and entry 1 reads as an unlinked, present
// entry until it is first written. An insert takes the next sequential id and
// places it left or right of a present reference entry; a remove unlinks an
// entry; a read returns an entry's neighbors and presence. Every result carries
// the current head, which is held in a register. A command is carried out in
// steps: the link words of the target are read in the accept cycle, the first
// link writes are made when the read data returns, and the second writes go out
// together with the result. The next command is taken in the cycle after that,
// so commands do not overlap. This is set by the single write port of each link
// memory, since an insert or a remove may touch two entries of the same memory.
// While a result waits at the output the next command is still accepted, but it
// holds in its final cycle, repeating its second writes, until the output
// register is free to receive its result.
`timescale 1ns / 1ps
`default_nettype none
module array_doubly_linked_list #(
  parameter int unsigned MAX_IDS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Command beats.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: ref_id [10:0], zeros above.
  input  wire logic [15:0] s_axis_tdata_i,
  // tuser: cmd [1:0], side [2].
  input  wire logic [2:0]  s_axis_tuser_i,
  // Result beats.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: new_id [10:0], prev_id [21:11], next_id [32:22], present [33],
  // head_id [44:34], zeros above.
  output logic      [47:0] m_axis_tdata_o,
  // tuser: status [1:0].
  output logic      [1:0]  m_axis_tuser_o
);

  localparam int unsigned IdW   = adl_pkg::IdW;
  localparam int unsigned CntW  = $clog2(MAX_IDS + 2);
  // Ids and links are kept wide enough for both the port field and the free count.
  localparam int unsigned WideW = (IdW > CntW) ? IdW : CntW;
  localparam int unsigned AddrW = $clog2(MAX_IDS);
  localparam logic [WideW-1:0] MaxPlus1 = WideW'(MAX_IDS + 1);
  localparam logic [WideW-1:0] IdOne    = WideW'(1);
  localparam logic [WideW-1:0] IdTwo    = WideW'(2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  function automatic logic [AddrW-1:0] to_addr(input logic [WideW-1:0] id);
    logic [WideW-1:0] idx;
    idx = id - IdOne;
    return idx[AddrW-1:0];
  endfunction

  // Sequencer and list registers.
  logic [1:0]       state_q, state_d;
  adl_pkg::cmd_t    cmd_q;
  logic [WideW-1:0] ref_q;
  logic             side_q;
  logic [WideW-1:0] free_q, free_d;
  logic [WideW-1:0] head_q, head_d;
  logic             l1_vld_q, r1_vld_q;

  // Second-phase writes, prepared when the read data returns.
  logic             fl_we_q, fr_we_q;
  logic [AddrW-1:0] fl_addr_q, fr_addr_q;
  logic [WideW:0]   fl_data_q;
  logic [WideW-1:0] fr_data_q;
  logic             fl_we_d, fr_we_d;
  logic [AddrW-1:0] fl_addr_d, fr_addr_d;
  logic [WideW:0]   fl_data_d;
  logic [WideW-1:0] fr_data_d;

  // Result fields held until the output register is free.
  adl_pkg::status_t res_status_q;
  logic [WideW-1:0] res_new_q, res_prev_q, res_next_q;
  logic             res_pres_q;

  // Output register.
  logic             m_valid_q;
  adl_pkg::status_t m_status_q;
  logic [IdW-1:0]   m_new_q, m_prev_q, m_next_q, m_head_q;
  logic             m_pres_q;

  // Memory ports. The left word carries the presence bit above the link.
  logic             wl_we, wr_we;
  logic [AddrW-1:0] wl_addr, wr_addr;
  logic [WideW:0]   wl_data;
  logic [WideW-1:0] wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [WideW:0]   left_rd;
  logic [WideW-1:0] right_rd;

  logic             in_accept, out_free;
  logic [WideW-1:0] in_ref;

  // Decoded view of the target entry in the execute cycle.
  logic             is_one, pres_raw, present, ins_ok, rem_ok;
  logic [WideW-1:0] l_val, r_val;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign in_ref          = WideW'(s_axis_tdata_i[IdW-1:0]);

  assign rd_en   = in_accept;
  assign rd_addr = to_addr(in_ref);

  adl_ram #(
    .Width(WideW + 1),
    .Depth(MAX_IDS),
    .AddrW(AddrW)
  ) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (wl_we),
    .waddr_i(wl_addr),
    .wdata_i(wl_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(left_rd)
  );

  adl_ram #(
    .Width(WideW),
    .Depth(MAX_IDS),
    .AddrW(AddrW)
  ) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (wr_we),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(right_rd)
  );

  // Entry 1 is present with null links until its words are first written.
  // Entries at or above the free id were never written and count as absent.
  always_comb begin
    is_one   = (ref_q == IdOne);
    pres_raw = (is_one && !l1_vld_q) ? 1'b1 : left_rd[WideW];
    l_val    = (is_one && !l1_vld_q) ? '0 : left_rd[WideW-1:0];
    r_val    = (is_one && !r1_vld_q) ? '0 : right_rd;
    present  = (ref_q != '0) && (ref_q < free_q) && pres_raw;
    ins_ok   = (cmd_q == adl_pkg::CMD_INSERT) && present && (free_q != MaxPlus1);
    rem_ok   = (cmd_q == adl_pkg::CMD_REMOVE) && present;
  end

  // Link writes: the first half in the execute cycle, the rest in the final one.
  always_comb begin
    wl_we   = 1'b0;
    wl_addr = '0;
    wl_data = '0;
    wr_we   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_q)
      S_EXEC: begin
        if (ins_ok) begin
          wl_we   = 1'b1;
          wl_addr = to_addr(free_q);
          wl_data = side_q ? {1'b1, ref_q} : {1'b1, l_val};
          wr_we   = 1'b1;
          wr_addr = to_addr(free_q);
          wr_data = side_q ? r_val : ref_q;
        end else if (rem_ok) begin
          wl_we   = 1'b1;
          wl_addr = to_addr(ref_q);
          wl_data = {1'b0, l_val};
          wr_we   = (l_val != '0);
          wr_addr = to_addr(l_val);
          wr_data = r_val;
        end
      end
      S_FIN: begin
        // Repeating these while the result waits rewrites the same values.
        wl_we   = fl_we_q;
        wl_addr = fl_addr_q;
        wl_data = fl_data_q;
        wr_we   = fr_we_q;
        wr_addr = fr_addr_q;
        wr_data = fr_data_q;
      end
      default: begin
      end
    endcase
  end

  // Second-phase writes of the command in execution: the neighbor links that
  // point at the new entry, or the left link of the right neighbor on a remove.
  always_comb begin
    fl_we_d   = 1'b0;
    fl_addr_d = to_addr(ref_q);
    fl_data_d = {1'b1, free_q};
    fr_we_d   = 1'b0;
    fr_addr_d = to_addr(ref_q);
    fr_data_d = free_q;
    if (ins_ok && side_q) begin
      fr_we_d   = 1'b1;
      fl_we_d   = (r_val != '0);
      fl_addr_d = to_addr(r_val);
    end else if (ins_ok) begin
      fl_we_d   = 1'b1;
      fr_we_d   = (l_val != '0);
      fr_addr_d = to_addr(l_val);
    end else if (rem_ok) begin
      fl_we_d   = (r_val != '0);
      fl_addr_d = to_addr(r_val);
      fl_data_d = {1'b1, l_val};
    end
  end

  always_comb begin
    state_d = state_q;
    free_d  = free_q;
    head_d  = head_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        if (ins_ok) begin
          free_d = free_q + IdOne;
          if (!side_q && (l_val == '0)) begin
            head_d = free_q;
          end
        end else if (rem_ok && (l_val == '0)) begin
          head_d = r_val;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      free_q    <= IdTwo;
      head_q    <= IdOne;
      l1_vld_q  <= 1'b0;
      r1_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      head_q  <= head_d;
      if (wl_we && (wl_addr == '0)) begin
        l1_vld_q <= 1'b1;
      end
      if (wr_we && (wr_addr == '0)) begin
        r1_vld_q <= 1'b1;
      end
      if ((state_q == S_FIN) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= adl_pkg::cmd_t'(s_axis_tuser_i[1:0]);
      side_q <= s_axis_tuser_i[2];
      ref_q  <= in_ref;
    end
    if (state_q == S_EXEC) begin
      fl_we_q   <= fl_we_d;
      fl_addr_q <= fl_addr_d;
      fl_data_q <= fl_data_d;
      fr_we_q   <= fr_we_d;
      fr_addr_q <= fr_addr_d;
      fr_data_q <= fr_data_d;

      if ((cmd_q == adl_pkg::CMD_INSERT) && !ins_ok) begin
        res_status_q <= adl_pkg::ST_REFUSED;
      end else if ((cmd_q == adl_pkg::CMD_REMOVE) && !present) begin
        res_status_q <= adl_pkg::ST_ABSENT;
      end else begin
        res_status_q <= adl_pkg::ST_DONE;
      end
      res_new_q  <= ins_ok ? free_q : '0;
      res_pres_q <= (cmd_q == adl_pkg::CMD_READ) && present;
      res_prev_q <= ((cmd_q == adl_pkg::CMD_READ) && present) ? l_val : '0;
      res_next_q <= ((cmd_q == adl_pkg::CMD_READ) && present) ? r_val : '0;
    end
    if ((state_q == S_FIN) && out_free) begin
      m_status_q <= res_status_q;
      m_new_q    <= res_new_q[IdW-1:0];
      m_prev_q   <= res_prev_q[IdW-1:0];
      m_next_q   <= res_next_q[IdW-1:0];
      m_pres_q   <= res_pres_q;
      m_head_q   <= head_q[IdW-1:0];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {3'b000, m_head_q, m_pres_q, m_next_q, m_prev_q, m_new_q};

  // The free id never runs past one beyond the last id.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= MaxPlus1)
    else $error("free id out of range");

  // An accepted command is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC))
    else $error("accepted command not executed");

  // An empty list has no present reference, so no insert can succeed.
  a_empty_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EXEC) && (head_q == '0)) |-> !ins_ok)
    else $error("insert succeeded on an empty list");

  // The free id moves only as the result of an execute cycle.
  a_free_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != $past(free_q)) |-> ($past(state_q) == S_EXEC))
    else $error("free id changed outside execution");

  // Only a successful insert reports a new id.
  a_new_id_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q != adl_pkg::ST_DONE)) |-> (m_new_q == '0))
    else $error("new id reported on a failed command");

endmodule
`default_nettype wire

FILE: rtl/adl_ram.sv
// Link memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module adl_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: tb/sv/array_doubly_linked_list_test.sv
// Self-checking testbench for the array-backed doubly linked list block.
`timescale 1ns / 1ps
module array_doubly_linked_list_test;
  import adl_pkg::*;

  localparam int unsigned MaxIds = 1024;
  // Cycles with nothing accepted on either side before the run is called hung.
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 200;
  localparam int DrainCycles = 10;

  localparam cmd_t CmdUnused = 2'd3;

  typedef logic [IdW-1:0] id_t;

  typedef struct packed {
    status_t status;
    id_t     new_id;
    id_t     prev_id;
    id_t     next_id;
    logic    present;
    id_t     head_id;
  } list_res_t;

  // One directed command; when typed is set, res is the result written out by hand.
  typedef struct packed {
    cmd_t      cmd;
    id_t       id;
    logic      side;
    logic      typed;
    list_res_t res;
  } dir_row_t;

  localparam dir_row_t DirRows [24] = '{
    // Straight out of reset: only entry 1, unlinked, is the head.
    '{CMD_READ,   11'd1,    1'b0, 1'b1, '{ST_DONE,    11'd0, 11'd0, 11'd0, 1'b1, 11'd1}},
    // Ids outside 1..MaxIds count as absent.
    '{CMD_READ,   11'd0,    1'b0, 1'b1, '{ST_DONE,    11'd0, 11'd0, 11'd0, 1'b0, 11'd1}},
    '{CMD_READ,   11'd2047, 1'b1, 1'b1, '{ST_DONE,    11'd0, 11'd0, 11'd0, 1'b0, 11'd1}},
    '{CMD_REMOVE, 11'd0,    1'b0, 1'b1, '{ST_ABSENT,  11'd0, 11'd0, 11'd0, 1'b0, 11'd1}},
    '{CMD_REMOVE, 11'd2047, 1'b1, 1'b1, '{ST_ABSENT,  11'd0, 11'd0, 11'd0, 1'b0, 11'd1}},
    // Inserts against a reference that is not in the list are refused.
    '{CMD_INSERT, 11'd0,    1'b0, 1'b1, '{ST_REFUSED, 11'd0, 11'd0, 11'd0, 1'b0, 11'd1}},
    '{CMD_INSERT, 11'd1024, 1'b1, 1'b1, '{ST_REFUSED, 11'd0, 11'd0, 11'd0, 1'b0, 11'd1}},
    // Build 3,5,1,2,4 with inserts on both sides, including a new head.
    '{CMD_INSERT, 11'd1,    1'b1, 1'b0, '0},
    '{CMD_INSERT, 11'd1,    1'b0, 1'b0, '0},
    '{CMD_INSERT, 11'd2,    1'b1, 1'b0, '0},
    '{CMD_INSERT, 11'd1,    1'b0, 1'b0, '0},
    '{CMD_READ,   11'd1,    1'b0, 1'b0, '0},
    '{CMD_READ,   11'd3,    1'b1, 1'b0, '0},
    '{CMD_READ,   11'd4,    1'b0, 1'b0, '0},
    // Unlink the head, the tail and a middle entry, then the middle one again.
    '{CMD_REMOVE, 11'd3,    1'b0, 1'b0, '0},
    '{CMD_REMOVE, 11'd4,    1'b1, 1'b0, '0},
    '{CMD_REMOVE, 11'd1,    1'b0, 1'b0, '0},
    '{CMD_REMOVE, 11'd1,    1'b1, 1'b0, '0},
    '{CMD_READ,   11'd1,    1'b0, 1'b0, '0},
    // A removed id is no longer a valid reference.
    '{CMD_INSERT, 11'd3,    1'b1, 1'b0, '0},
    '{CmdUnused,  11'd5,    1'b1, 1'b0, '0},
    '{CMD_INSERT, 11'd2,    1'b1, 1'b0, '0},
    '{CMD_READ,   11'd2047, 1'b1, 1'b0, '0},
    '{CMD_READ,   11'd6,    1'b0, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic [15:0] cmd_data = '0;
  logic [2:0]  cmd_user = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [47:0] res_data;
  logic [1:0]  res_user;

  // Mirror of the list: link words, presence, head and the next id to hand out.
  id_t  left_of [1:MaxIds];
  id_t  right_of [1:MaxIds];
  logic on_list [1:MaxIds];
  id_t  head_reg;
  id_t  free_id;

  list_res_t pending_q [$];
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_reqs = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  array_doubly_linked_list #(
    .MAX_IDS(MaxIds)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(cmd_valid),
    .s_axis_tready_o(cmd_ready),
    .s_axis_tdata_i (cmd_data),
    .s_axis_tuser_i (cmd_user),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_data),
    .m_axis_tuser_o (res_user)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic id_on_list(id_t id);
    if (id >= 1 && id <= MaxIds) return on_list[id];
    return 1'b0;
  endfunction

  // Applies one command to the mirror and returns the result beat it must produce.
  function automatic list_res_t apply_list_cmd(cmd_t c, id_t id, logic side);
    list_res_t r;
    id_t       n;
    id_t       l;
    id_t       rt;
    r = '0;
    r.status = ST_DONE;
    case (c)
      CMD_INSERT: begin
        if (!id_on_list(id) || free_id > MaxIds) begin
          r.status = ST_REFUSED;
        end else begin
          n = free_id;
          if (side) begin
            rt = right_of[id];
            right_of[n] = rt;
            if (rt != 0) left_of[rt] = n;
            right_of[id] = n;
            left_of[n] = id;
          end else begin
            l = left_of[id];
            left_of[n] = l;
            if (l != 0) right_of[l] = n;
            else head_reg = n;
            right_of[n] = id;
            left_of[id] = n;
          end
          on_list[n] = 1'b1;
          free_id = n + 1;
          r.new_id = n;
        end
      end
      CMD_REMOVE: begin
        if (!id_on_list(id)) begin
          r.status = ST_ABSENT;
        end else begin
          l = left_of[id];
          rt = right_of[id];
          if (l != 0) right_of[l] = rt;
          else head_reg = rt;
          if (rt != 0) left_of[rt] = l;
          on_list[id] = 1'b0;
        end
      end
      CMD_READ: begin
        if (id_on_list(id)) begin
          r.present = 1'b1;
          r.prev_id = left_of[id];
          r.next_id = right_of[id];
        end
      end
      default: begin
      end
    endcase
    r.head_id = head_reg;
    return r;
  endfunction

  // Mostly ids that were handed out, some the head, the rest anything the field can hold.
  function automatic id_t pick_id();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return id_t'($urandom_range(1, (free_id > MaxIds) ? MaxIds : free_id - 1));
    if (k < 80) return head_reg;
    return id_t'($urandom_range(0, 2 ** IdW - 1));
  endfunction

  // Offers one command beat, waits for it to be taken and queues its expected result.
  task automatic issue_cmd(cmd_t c, id_t id, logic side, logic typed, list_res_t typed_res);
    logic      taken;
    list_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= {{(16 - IdW){1'b0}}, id};
    cmd_user  <= {side, c};
    // Handshake values are read at the falling edge, where they are settled.
    do begin
      @(negedge clk_i);
      taken = cmd_ready;
      @(posedge clk_i);
    end while (!taken);
    pred = apply_list_cmd(c, id, side);
    pending_q.push_back(typed ? typed_res : pred);
  endtask

  // Stops offering and waits until every queued result has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  task automatic run_random(int count);
    cmd_t        c;
    id_t         id;
    int unsigned k;
    repeat (count) begin
      k = $urandom_range(99);
      if (k < 50) c = CMD_INSERT;
      else if (k < 70) c = CMD_REMOVE;
      else if (k < 95) c = CMD_READ;
      else c = CmdUnused;
      id = pick_id();
      // The list is only emptied at the very end, since nothing can be inserted after.
      if (c == CMD_REMOVE && id_on_list(id) && left_of[id] == 0 && right_of[id] == 0) begin
        c = CMD_READ;
      end
      issue_cmd(c, id, 1'($urandom_range(1)), 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Result side ready: random idling, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each result beat is compared with the oldest expectation when it is taken.
  always @(negedge clk_i) begin : result_check
    list_res_t got;
    list_res_t want;
    if (rst_ni && res_valid && res_ready) begin
      got = '{res_user, res_data[10:0], res_data[21:11], res_data[32:22], res_data[33],
              res_data[44:34]};
      if (pending_q.size() == 0) begin
        $error("result beat with no command waiting for it");
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("status", want.status, got.status);
        check_field("new_id", want.new_id, got.new_id);
        check_field("prev_id", want.prev_id, got.prev_id);
        check_field("next_id", want.next_id, got.next_id);
        check_field("present", want.present, got.present);
        check_field("head_id", want.head_id, got.head_id);
      end
    end
  end

  initial begin : watchdog
    int stall_cnt;
    stall_cnt = 0;
    while (stall_cnt < StallLimit) begin
      @(negedge clk_i);
      if (rst_ni && !(cmd_valid && cmd_ready) && !(res_valid && res_ready)) stall_cnt++;
      else stall_cnt = 0;
    end
    $error("no beat moved for %0d cycles", StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int  i;
    id_t id;
    for (i = 1; i <= MaxIds; i++) begin
      left_of[i]  = '0;
      right_of[i] = '0;
      on_list[i]  = 1'b0;
    end
    on_list[1] = 1'b1;
    head_reg   = 1;
    free_id    = 2;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct <= 14;
    recv_idle_pct <= 79;
    @(posedge clk_i);

    for (i = 0; i < $size(DirRows); i++) begin
      issue_cmd(DirRows[i].cmd, DirRows[i].id, DirRows[i].side, DirRows[i].typed,
                DirRows[i].res);
    end
    drain_results();
    run_random(160);

    drain_results();
    send_idle_pct <= 79;
    recv_idle_pct <= 14;
    run_random(160);

    // No idling from here on; the receiver first holds off so the block backs up.
    drain_results();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    run_random(160);

    // Remove entries until the list is empty, with some removes of absent ids mixed in.
    while (head_reg != 0) begin
      id = pick_id();
      if ($urandom_range(9) != 0 && !id_on_list(id)) id = head_reg;
      issue_cmd(CMD_REMOVE, id, 1'($urandom_range(1)), 1'b0, '0);
    end
    // With the list empty every insert is refused and every read finds nothing.
    repeat (8) issue_cmd(cmd_t'($urandom_range(3)), pick_id(), 1'($urandom_range(1)), 1'b0, '0);

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
